// ----- rtl/mhq_pkg.sv -----
// Shared types, constants and command/status bundles of the hull max-query core.
// Used by every module of the block; depends on nothing.
package mhq_pkg;

  localparam int DEPTH   = 64;
  localparam int IDX_W   = $clog2(DEPTH);
  localparam int CNT_W   = IDX_W + 1;
  localparam int CW      = 32;
  localparam int BPW     = CW + 2;
  localparam int DIVW    = CW + 1;
  localparam int DCNT_W  = $clog2(DIVW + 1);

  localparam logic signed [BPW-1:0] BP_POS_INF = {1'b0, {(BPW-1){1'b1}}};
  localparam logic signed [BPW-1:0] BP_NEG_INF = {1'b1, {(BPW-1){1'b0}}};

  localparam logic       FN_INSERT = 1'b0;
  localparam logic       FN_QUERY  = 1'b1;
  localparam logic [1:0] ST_OK     = 2'd0;
  localparam logic [1:0] ST_EMPTY  = 2'd1;
  localparam logic [1:0] ST_FULL   = 2'd2;

  typedef struct packed {
    logic               func;
    logic signed [31:0] slope;
    logic signed [31:0] intercept;
    logic signed [31:0] x;
  } mhq_in_t;

  typedef struct packed {
    logic signed [63:0] value;
    logic [1:0]         status;
  } mhq_out_t;

  typedef enum logic [1:0] {
    RD_HEAD = 2'd0,
    RD_BACK = 2'd1,
    RD_PREV = 2'd2
  } rd_sel_t;

  typedef struct packed {
    logic       latch;
    logic       rd_en;
    rd_sel_t    rd_sel;
    logic       set_bp_eq;
    logic       div_start;
    logic       take_div;
    logic       wr_bp;
    logic       wr_app;
    logic       drop_back;
    logic       drop_front;
    logic       mul;
    logic       emit;
    logic       emit_val;
    logic [1:0] emit_status;
  } mhq_cmd_t;

  typedef struct packed {
    logic func;
    logic full;
    logic empty;
    logic cnt_ge2;
    logic slope_eq;
    logic dominated;
    logic div_done;
    logic prev_below;
    logic front_below;
  } mhq_stat_t;

endpackage

// ----- rtl/mhq_div.sv -----
// Serial floor divider, one quotient bit per cycle, for breakpoint placement.
// Depends on mhq_pkg.
module mhq_div import mhq_pkg::*; (
  input  logic                   clk,
  input  logic                   rst_n,
  input  logic                   start,
  input  logic signed [DIVW-1:0] num,
  input  logic signed [DIVW-1:0] den,
  output logic                   done,
  output logic signed [BPW-1:0]  quot
);

  logic [DIVW:0]     rem_r;
  logic [DIVW-1:0]   quo_r;
  logic [DIVW-1:0]   dm_r;
  logic              neg_r;
  logic [DCNT_W-1:0] cnt_r;
  logic              run_r;
  logic              done_r;
  logic [DIVW:0]     shifted;
  logic [DIVW:0]     trial;
  logic [DIVW-1:0]   n_mag;
  logic [DIVW-1:0]   d_mag;

  assign n_mag   = num[DIVW-1] ? DIVW'(-num) : DIVW'(num);
  assign d_mag   = den[DIVW-1] ? DIVW'(-den) : DIVW'(den);
  assign shifted = {rem_r[DIVW-1:0], quo_r[DIVW-1]};
  assign trial   = shifted - {1'b0, dm_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      done_r <= 1'b0;
      if (start) begin
        run_r <= 1'b1;
        cnt_r <= DCNT_W'(DIVW);
      end else if (run_r) begin
        cnt_r <= cnt_r - 1'b1;
        if (cnt_r == DCNT_W'(1)) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      rem_r <= '0;
      quo_r <= n_mag;
      dm_r  <= d_mag;
      neg_r <= num[DIVW-1] ^ den[DIVW-1];
    end else if (run_r) begin
      if (!trial[DIVW]) begin
        rem_r <= trial;
        quo_r <= {quo_r[DIVW-2:0], 1'b1};
      end else begin
        rem_r <= shifted;
        quo_r <= {quo_r[DIVW-2:0], 1'b0};
      end
    end
  end

  // floor toward minus infinity: negative with remainder rounds one further down
  always_comb begin
    if (!neg_r)
      quot = {1'b0, quo_r};
    else if (rem_r != '0)
      quot = ~{1'b0, quo_r};
    else
      quot = -{1'b0, quo_r};
  end

  assign done = done_r;

endmodule

// ----- rtl/mhq_dp.sv -----
// Datapath: line ring memories, head/count, breakpoint divider, multiplier and result beat.
// Depends on mhq_pkg and mhq_div.
module mhq_dp import mhq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  mhq_in_t   in_item,
  input  mhq_cmd_t  cmd,
  output mhq_stat_t stat,
  output logic      out_strobe,
  output mhq_out_t  out_item
);

  logic signed [CW-1:0]  mem_slope [DEPTH];
  logic signed [CW-1:0]  mem_int   [DEPTH];
  logic signed [BPW-1:0] mem_bp    [DEPTH];

  logic signed [CW-1:0]  rd_slope_r, rd_int_r;
  logic signed [BPW-1:0] rd_bp_r;
  logic signed [CW-1:0]  a_r, b_r, x_r;
  logic                  func_r;
  logic signed [BPW-1:0] bp_r;
  logic signed [63:0]    prod_r;
  logic [IDX_W-1:0]      head_r;
  logic [CNT_W-1:0]      count_r;
  logic                  out_strobe_r;
  mhq_out_t              out_r;

  logic [IDX_W-1:0]      slot_back, slot_prev, slot_app, rd_addr, wr_addr;
  logic signed [BPW-1:0] x_ext;
  logic                  div_done;
  logic signed [BPW-1:0] div_q;
  logic signed [DIVW-1:0] div_n, div_d;

  assign slot_app  = head_r + count_r[IDX_W-1:0];
  assign slot_back = head_r + IDX_W'(count_r - 1'b1);
  assign slot_prev = head_r + IDX_W'(count_r - 2'd2);
  assign x_ext     = BPW'(x_r);

  always_comb begin
    case (cmd.rd_sel)
      RD_BACK: rd_addr = slot_back;
      RD_PREV: rd_addr = slot_prev;
      default: rd_addr = head_r;
    endcase
  end

  assign wr_addr = cmd.wr_app ? slot_app : slot_back;

  always_ff @(posedge clk) begin
    if (cmd.rd_en) begin
      rd_slope_r <= mem_slope[rd_addr];
      rd_int_r   <= mem_int[rd_addr];
      rd_bp_r    <= mem_bp[rd_addr];
    end
    if (cmd.wr_app) begin
      mem_slope[wr_addr] <= a_r;
      mem_int[wr_addr]   <= b_r;
    end
    if (cmd.wr_app || cmd.wr_bp)
      mem_bp[wr_addr] <= cmd.wr_app ? BP_POS_INF : bp_r;
  end

  assign div_n = DIVW'(b_r) - DIVW'(rd_int_r);
  assign div_d = DIVW'(rd_slope_r) - DIVW'(a_r);

  mhq_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .start (cmd.div_start),
    .num   (div_n),
    .den   (div_d),
    .done  (div_done),
    .quot  (div_q)
  );

  always_ff @(posedge clk) begin
    if (cmd.latch) begin
      func_r <= in_item.func;
      a_r    <= in_item.slope;
      b_r    <= in_item.intercept;
      x_r    <= in_item.x;
    end
    if (cmd.set_bp_eq)
      bp_r <= (rd_int_r > b_r) ? BP_POS_INF : BP_NEG_INF;
    else if (cmd.take_div)
      bp_r <= div_q;
    if (cmd.mul)
      prod_r <= rd_slope_r * x_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      head_r       <= '0;
      count_r      <= '0;
      out_strobe_r <= 1'b0;
    end else begin
      out_strobe_r <= cmd.emit;
      if (cmd.wr_app)
        count_r <= count_r + 1'b1;
      else if (cmd.drop_back)
        count_r <= count_r - 1'b1;
      else if (cmd.drop_front) begin
        count_r <= count_r - 1'b1;
        head_r  <= head_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.emit) begin
      out_r.status <= cmd.emit_status;
      out_r.value  <= cmd.emit_val ? (prod_r + 64'(rd_int_r)) : 64'sd0;
    end
  end

  assign stat.func        = func_r;
  assign stat.full        = (count_r == CNT_W'(DEPTH));
  assign stat.empty       = (count_r == '0);
  assign stat.cnt_ge2     = (count_r >= CNT_W'(2));
  assign stat.slope_eq    = (rd_slope_r == a_r);
  assign stat.dominated   = (rd_slope_r == a_r) && (rd_int_r >= b_r);
  assign stat.div_done    = div_done;
  assign stat.prev_below  = (rd_bp_r < bp_r);
  assign stat.front_below = (rd_bp_r < x_ext);

  assign out_strobe = out_strobe_r;
  assign out_item   = out_r;

endmodule

// ----- rtl/mhq_ctrl.sv -----
// Controller: sequences inserts (back pops with serial breakpoint division) and queries.
// Depends on mhq_pkg.
module mhq_ctrl import mhq_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      start,
  output logic      busy,
  input  mhq_stat_t stat,
  output mhq_cmd_t  cmd
);

  typedef enum logic [10:0] {
    S_IDLE  = 11'b00000000001,
    S_DISP  = 11'b00000000010,
    S_I_RDB = 11'b00000000100,
    S_I_CMP = 11'b00000001000,
    S_I_DIV = 11'b00000010000,
    S_I_WRB = 11'b00000100000,
    S_I_RDP = 11'b00001000000,
    S_I_CHP = 11'b00010000000,
    S_I_APP = 11'b00100000000,
    S_Q_CHK = 11'b01000000000,
    S_Q_MUL = 11'b10000000000
  } state_t;

  state_t state_r, state_nxt;
  logic   first_r, first_nxt;
  logic   q_out_r, q_out_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
      first_r <= 1'b0;
      q_out_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      first_r <= first_nxt;
      q_out_r <= q_out_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  always_comb begin
    state_nxt = state_r;
    first_nxt = first_r;
    q_out_nxt = 1'b0;
    cmd       = '0;
    cmd.rd_sel = RD_HEAD;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          cmd.latch = 1'b1;
          state_nxt = S_DISP;
        end
      end
      S_DISP: begin
        if (stat.func == FN_QUERY) begin
          if (stat.empty) begin
            cmd.emit        = 1'b1;
            cmd.emit_status = ST_EMPTY;
            state_nxt       = S_IDLE;
          end else begin
            cmd.rd_en = 1'b1;
            state_nxt = S_Q_CHK;
          end
        end else if (stat.full) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = ST_FULL;
          state_nxt       = S_IDLE;
        end else if (stat.empty) begin
          state_nxt = S_I_APP;
        end else begin
          first_nxt = 1'b1;
          state_nxt = S_I_RDB;
        end
      end
      S_I_RDB: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_BACK;
        state_nxt  = S_I_CMP;
      end
      S_I_CMP: begin
        if (first_r && stat.dominated) begin
          cmd.emit        = 1'b1;
          cmd.emit_status = ST_OK;
          state_nxt       = S_IDLE;
        end else if (stat.slope_eq) begin
          cmd.set_bp_eq = 1'b1;
          state_nxt     = S_I_WRB;
        end else begin
          cmd.div_start = 1'b1;
          state_nxt     = S_I_DIV;
        end
      end
      S_I_DIV: begin
        if (stat.div_done) begin
          cmd.take_div = 1'b1;
          state_nxt    = S_I_WRB;
        end
      end
      S_I_WRB: begin
        cmd.wr_bp = 1'b1;
        state_nxt = stat.cnt_ge2 ? S_I_RDP : S_I_APP;
      end
      S_I_RDP: begin
        cmd.rd_en  = 1'b1;
        cmd.rd_sel = RD_PREV;
        state_nxt  = S_I_CHP;
      end
      S_I_CHP: begin
        if (stat.prev_below) begin
          state_nxt = S_I_APP;
        end else begin
          // drop the back entry; the read data already holds the new back line
          cmd.drop_back = 1'b1;
          first_nxt     = 1'b0;
          state_nxt     = S_I_CMP;
        end
      end
      S_I_APP: begin
        cmd.wr_app      = 1'b1;
        cmd.emit        = 1'b1;
        cmd.emit_status = ST_OK;
        state_nxt       = S_IDLE;
      end
      S_Q_CHK: begin
        if (stat.front_below) begin
          cmd.drop_front = 1'b1;
          state_nxt      = S_DISP;
        end else begin
          cmd.mul   = 1'b1;
          state_nxt = S_Q_MUL;
        end
      end
      S_Q_MUL: begin
        if (q_out_r) begin
          cmd.emit        = 1'b1;
          cmd.emit_val    = 1'b1;
          cmd.emit_status = ST_OK;
          state_nxt       = S_IDLE;
        end else begin
          q_out_nxt = 1'b1;
        end
      end
      default: state_nxt = S_IDLE;
    endcase
  end

endmodule

// ----- rtl/monotonic_hull_max_query_core.sv -----
// Hull max-query core, one item at a time. A query pops front entries whose breakpoint lies
// below x, then emits the front line's value; an empty store reports ST_EMPTY. An insert sets
// breakpoints by serial division (not for equal slopes), pops back lines it hides, drops a
// dominated line, flags a full store. A new item may be taken in the result beat's cycle.
// Synchronous active-low reset empties the ring; line memories are left unwritten.
// The receiver cannot stall: each result is shown for one cycle only.
module monotonic_hull_max_query_core import mhq_pkg::*; (
  input  logic     clk,
  input  logic     rst_n,
  input  logic     start,
  output logic     busy,
  input  mhq_in_t  in_item,
  output logic     out_strobe,
  output mhq_out_t out_item
);

  mhq_cmd_t  cmd;
  mhq_stat_t stat;

  mhq_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .start (start),
    .busy  (busy),
    .stat  (stat),
    .cmd   (cmd)
  );

  mhq_dp u_dp (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_item    (in_item),
    .cmd        (cmd),
    .stat       (stat),
    .out_strobe (out_strobe),
    .out_item   (out_item)
  );

endmodule

// ----- rtl/mhq_checker.sv -----
// Port-level checks of the hull max-query core, bound to the top level.
// Depends on mhq_pkg.
module mhq_checker import mhq_pkg::*; (
  input logic     clk,
  input logic     rst_n,
  input logic     start,
  input logic     busy,
  input logic     out_strobe,
  input mhq_out_t out_item
);

  a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |=> busy)
    else $error("accepted beat did not raise busy");

  a_status_code: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |-> (out_item.status <= ST_FULL))
    else $error("result status code out of range");

  a_error_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_strobe && out_item.status != ST_OK) |-> (out_item.value == 64'sd0))
    else $error("error result carries a value");

  a_no_double: assert property (@(posedge clk) disable iff (!rst_n)
    out_strobe |=> !out_strobe)
    else $error("two result beats in a row");

endmodule

bind monotonic_hull_max_query_core mhq_checker u_mhq_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .start      (start),
  .busy       (busy),
  .out_strobe (out_strobe),
  .out_item   (out_item)
);
